@@ hw/rtl/sle_pkg.sv @@
// Shared field widths and request codes for the sequential list engine.
package sle_pkg;

  localparam int MODE_W = 2;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_SEARCH = 2'd2,
    MODE_GET    = 2'd3
  } mode_t;

endpackage

@@ hw/rtl/sequential_list_engine.sv @@
// Top level of the sequential list engine: sequencer plus entry RAM.
//
// A request is taken when start is high and busy is low; its single result
// beat appears on the result ports with done high for exactly one cycle and
// cannot be held off. Every entry moved or compared goes through the one
// read and one write port of the entry RAM, one entry per cycle, and the
// read port is registered. Insert at position p moves the entries from
// the tail down to p up by one place and then writes the new item, delete
// moves the entries after p down by one place, search compares entries
// from the first and stops at the first hit, get reads one entry, and a
// rejected request answers in the cycle after it is taken. busy stays
// high until the result is issued. The entry RAM needs no clearing after
// reset.
module sequential_list_engine #(
  parameter int CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [sle_pkg::MODE_W-1:0]  mode,
  input  logic [sle_pkg::POS_W-1:0]   position,
  input  logic signed [sle_pkg::DATA_W-1:0] item_value,
  output logic                        done,
  output logic                        ok,
  output logic [sle_pkg::POS_W-1:0]   found_position,
  output logic signed [sle_pkg::DATA_W-1:0] read_value,
  output logic [sle_pkg::POS_W-1:0]   list_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [sle_pkg::DATA_W-1:0]  mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [sle_pkg::DATA_W-1:0]  mem_rdata;
  logic [sle_pkg::DATA_W-1:0]  rd_value;

  assign read_value = rd_value;

  sle_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_seq (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .mode           (sle_pkg::mode_t'(mode)),
    .position       (position),
    .item_value     (item_value),
    .busy           (busy),
    .done           (done),
    .ok             (ok),
    .found_position (found_position),
    .read_value     (rd_value),
    .list_count     (list_count),
    .mem_we         (mem_we),
    .mem_waddr      (mem_waddr),
    .mem_wdata      (mem_wdata),
    .mem_re         (mem_re),
    .mem_raddr      (mem_raddr),
    .mem_rdata      (mem_rdata)
  );

  sle_ram #(
    .DEPTH  (CAPACITY),
    .AW     (AW),
    .DATA_W (sle_pkg::DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ hw/rtl/sle_ram.sv @@
// Entry store: simple dual-port RAM, one write and one registered read per cycle.
module sle_ram #(
  parameter int DEPTH  = 64,
  parameter int AW     = 6,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/sle_seq.sv @@
// Request sequencer: shifts, scans and reads the entry store one entry per cycle.
module sle_seq #(
  parameter int CAPACITY = 64,
  parameter int AW       = 6,
  parameter int CW       = 7
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  sle_pkg::mode_t               mode,
  input  logic [sle_pkg::POS_W-1:0]    position,
  input  logic [sle_pkg::DATA_W-1:0]   item_value,
  output logic                         busy,
  output logic                         done,
  output logic                         ok,
  output logic [sle_pkg::POS_W-1:0]    found_position,
  output logic [sle_pkg::DATA_W-1:0]   read_value,
  output logic [sle_pkg::POS_W-1:0]    list_count,
  output logic                         mem_we,
  output logic [AW-1:0]                mem_waddr,
  output logic [sle_pkg::DATA_W-1:0]   mem_wdata,
  output logic                         mem_re,
  output logic [AW-1:0]                mem_raddr,
  input  logic [sle_pkg::DATA_W-1:0]   mem_rdata
);

  localparam int XW = ((CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_SCAN,
    S_GET
  } state_t;

  state_t                       state;
  logic [CW-1:0]                count;
  logic [AW-1:0]                ptr;
  logic [AW-1:0]                lim;
  logic [AW-1:0]                tgt;
  logic                         iss_on;
  logic                         pvalid;
  logic [AW-1:0]                pidx;
  logic [sle_pkg::DATA_W-1:0]   val;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] cap_x;
  logic [XW-1:0] hit_x;
  logic [AW-1:0] pos_m1;
  logic [AW-1:0] cnt_m1;
  logic          pos_in_list;

  assign pos_x       = XW'(position);
  assign cnt_x       = XW'(count);
  assign cap_x       = XW'(CAPACITY);
  assign hit_x       = XW'(pidx) + XW'(1);
  assign pos_m1      = AW'(pos_x - XW'(1));
  assign cnt_m1      = AW'(cnt_x - XW'(1));
  assign pos_in_list = (pos_x != '0) && (pos_x <= cnt_x);
  assign busy        = (state != S_IDLE);

  always_comb begin
    mem_re    = iss_on;
    mem_raddr = ptr;
    mem_we    = 1'b0;
    mem_waddr = pidx;
    mem_wdata = mem_rdata;
    unique case (state)
      S_SHIFT_UP: begin
        if (pvalid) begin
          mem_we    = 1'b1;
          mem_waddr = pidx + AW'(1);
        end else if (!iss_on) begin
          mem_we    = 1'b1;
          mem_waddr = tgt;
          mem_wdata = val;
        end
      end
      S_SHIFT_DN: begin
        if (pvalid) begin
          mem_we    = 1'b1;
          mem_waddr = pidx - AW'(1);
        end
      end
      S_IDLE, S_SCAN, S_GET: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      iss_on <= 1'b0;
      pvalid <= 1'b0;
      done   <= 1'b0;
    end else begin
      done   <= 1'b0;
      pvalid <= iss_on;
      pidx   <= ptr;
      if (iss_on) begin
        if (ptr == lim) begin
          iss_on <= 1'b0;
        end else if (state == S_SHIFT_UP) begin
          ptr <= ptr - AW'(1);
        end else begin
          ptr <= ptr + AW'(1);
        end
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            val            <= item_value;
            ok             <= 1'b0;
            found_position <= '0;
            read_value     <= '0;
            list_count     <= sle_pkg::POS_W'(count);
            unique case (mode)
              sle_pkg::MODE_INSERT: begin
                if ((cnt_x < cap_x) && (pos_x != '0) && (pos_x <= cnt_x + XW'(1))) begin
                  state  <= S_SHIFT_UP;
                  tgt    <= pos_m1;
                  lim    <= pos_m1;
                  ptr    <= cnt_m1;
                  iss_on <= (pos_x != cnt_x + XW'(1));
                end else begin
                  done <= 1'b1;
                end
              end
              sle_pkg::MODE_DELETE: begin
                if (pos_in_list) begin
                  state  <= S_SHIFT_DN;
                  ptr    <= AW'(pos_x);
                  lim    <= cnt_m1;
                  iss_on <= (pos_x != cnt_x);
                end else begin
                  done <= 1'b1;
                end
              end
              sle_pkg::MODE_SEARCH: begin
                state  <= S_SCAN;
                ptr    <= '0;
                lim    <= cnt_m1;
                iss_on <= (count != '0);
              end
              sle_pkg::MODE_GET: begin
                if (pos_in_list) begin
                  state  <= S_GET;
                  ptr    <= pos_m1;
                  lim    <= pos_m1;
                  iss_on <= 1'b1;
                end else begin
                  done <= 1'b1;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_SHIFT_UP: begin
          if (!iss_on && !pvalid) begin
            count      <= count + CW'(1);
            list_count <= sle_pkg::POS_W'(count + CW'(1));
            ok         <= 1'b1;
            done       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_SHIFT_DN: begin
          if (!iss_on && !pvalid) begin
            count      <= count - CW'(1);
            list_count <= sle_pkg::POS_W'(count - CW'(1));
            ok         <= 1'b1;
            done       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (pvalid && (mem_rdata == val)) begin
            ok             <= 1'b1;
            found_position <= sle_pkg::POS_W'(hit_x);
            done           <= 1'b1;
            iss_on         <= 1'b0;
            pvalid         <= 1'b0;
            state          <= S_IDLE;
          end else if (!iss_on && !pvalid) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_GET: begin
          if (pvalid) begin
            ok         <= 1'b1;
            read_value <= mem_rdata;
            done       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
